[hdl/tcce_pkg.sv]
// Shared types, codes and constants of the text console character engine.
package tcce_pkg;

  // Default screen geometry
  localparam int DEF_ROWS       = 25;
  localparam int DEF_COLS       = 80;
  localparam int DEF_CLOCK_COLS = 65;

  // Port widths
  localparam int CHAR_W      = 8;
  localparam int IDX_W       = 11;
  localparam int ROW_OUT_W   = 5;
  localparam int COL_OUT_W   = 7;
  localparam int CELL_W      = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Cell values
  localparam logic [CELL_W-1:0] ATTR_WHITE = 16'h0F00;
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  // Command codes carried in tuser
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS         = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB        = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL         = 8'd10;
  localparam logic [CHAR_W-1:0] CH_FF         = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR         = 8'd13;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO   = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI   = 8'd126;

  localparam int TAB_STEP_LOG2 = 3;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_BS,
    OP_TAB,
    OP_NL,
    OP_CR,
    OP_FF,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } q_entry_t;

  typedef struct packed {
    logic [CELL_W-1:0]    data;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
  } out_item_t;

endpackage

[hdl/tcce_front.sv]
// Front end: accepts input items and classifies them into queue entries.
module tcce_front #(
  parameter int ROWS = tcce_pkg::DEF_ROWS,
  parameter int COLS = tcce_pkg::DEF_COLS
) (
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: char_code [7:0], cell_index [18:8], zero pad [23:19]
  input  logic [tcce_pkg::IN_TDATA_W-1:0] in_tdata,
  // tuser: cmd [0]
  input  logic [0:0]                      in_tuser,
  input  logic                            init_busy,
  input  logic                            q_full,
  output logic                            q_push,
  output tcce_pkg::q_entry_t              q_entry
);
  import tcce_pkg::*;

  localparam int CELLS = ROWS * COLS;

  logic [CHAR_W-1:0] ch;
  logic [IDX_W-1:0]  idx;

  assign ch  = in_tdata[CHAR_W-1:0];
  assign idx = in_tdata[CHAR_W +: IDX_W];

  // Hold off while the screen is cleared after reset
  assign in_tready = !init_busy && !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_entry.ch  = ch;
    q_entry.idx = idx;
    if (in_tuser[0] == CMD_READ) begin
      // A read beyond the screen changes nothing and returns zero
      q_entry.op = (32'(idx) < CELLS) ? OP_READ : OP_NOP;
    end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
      q_entry.op = OP_PUT;
    end else begin
      case (ch)
        CH_BS:   q_entry.op = OP_BS;
        CH_TAB:  q_entry.op = OP_TAB;
        CH_NL:   q_entry.op = OP_NL;
        CH_CR:   q_entry.op = OP_CR;
        CH_FF:   q_entry.op = OP_FF;
        default: q_entry.op = OP_NOP;
      endcase
    end
  end

endmodule

[hdl/tcce_queue.sv]
// Short queue of classified items between the front and the back.
module tcce_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tcce_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output tcce_pkg::q_entry_t head_entry
);
  import tcce_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[hdl/tcce_back.sv]
// Back end: cursor, screen memory, scroll and clear sequencer, output register.
module tcce_back #(
  parameter int ROWS       = tcce_pkg::DEF_ROWS,
  parameter int COLS       = tcce_pkg::DEF_COLS,
  parameter int CLOCK_COLS = tcce_pkg::DEF_CLOCK_COLS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_keep,
  input  logic                q_valid,
  input  tcce_pkg::q_entry_t  q_entry,
  output logic                q_pop,
  output logic                init_busy,
  output logic                out_valid,
  input  logic                out_ready,
  output tcce_pkg::out_item_t out_item
);
  import tcce_pkg::*;

  localparam int CELLS       = ROWS * COLS;
  localparam int AW          = $clog2(CELLS);
  localparam int CNT_W       = $clog2(CELLS + 1);
  localparam int RW          = $clog2(ROWS);
  localparam int CW          = $clog2(COLS);
  localparam int SHIFT_CELLS = (ROWS - 1) * COLS;
  localparam int KEEP        = (CLOCK_COLS < COLS) ? CLOCK_COLS : COLS;

  state_t           state_r, state_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    pend_addr_r, pend_addr_nxt;
  logic             pend_blank_r, pend_blank_nxt;
  logic             keep_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_r;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [CELL_W-1:0] wdata;

  logic [AW-1:0] cur_addr;
  logic [CW:0]   tab_col;
  logic          out_free;
  logic          do_nl;
  logic          skip;

  assign cur_addr  = AW'(32'(row_r) * COLS + 32'(col_r));
  assign tab_col   = (CW+1)'(((32'(col_r) >> TAB_STEP_LOG2) + 1) << TAB_STEP_LOG2);
  assign out_free  = !out_valid_r || out_ready;
  assign init_busy = (state_r == ST_INIT);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    pend_blank_nxt = pend_blank_r;
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    we             = 1'b0;
    waddr          = cur_addr;
    wdata          = ATTR_WHITE | CELL_W'(q_entry.ch);
    raddr          = AW'(q_entry.idx);
    q_pop          = 1'b0;
    do_nl          = 1'b0;
    skip           = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_INIT, ST_FILL: begin
        we    = 1'b1;
        waddr = AW'(cnt_r);
        wdata = (state_r == ST_INIT) ? '0 : BLANK_CELL;
        if (cnt_r == CNT_W'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_entry.op)
            OP_PUT: begin
              we = 1'b1;
              if (col_r >= CW'(COLS - 1)) begin
                do_nl = 1'b1;
              end else begin
                col_nxt = col_r + CW'(1);
              end
            end
            OP_BS: begin
              if (col_r != '0) begin
                col_nxt = col_r - CW'(1);
              end
            end
            OP_TAB: begin
              col_nxt = (32'(tab_col) > COLS - 1) ? CW'(COLS - 1) : CW'(tab_col);
            end
            OP_NL: do_nl = 1'b1;
            OP_CR: col_nxt = '0;
            OP_FF: begin
              row_nxt   = '0;
              col_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = ST_FILL;
            end
            OP_READ: state_nxt = ST_READ;
            default: ;
          endcase
          if (do_nl) begin
            col_nxt = '0;
            if (row_r >= RW'(ROWS - 1)) begin
              row_nxt   = RW'(ROWS - 1);
              cnt_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = ST_SCROLL;
            end else begin
              row_nxt = row_r + RW'(1);
            end
          end
          // Deliver the result now; a read waits in ST_READ for its data
          if (q_entry.op != OP_READ) begin
            out_valid_nxt    = 1'b1;
            out_item_nxt.row = ROW_OUT_W'(row_nxt);
            out_item_nxt.col = COL_OUT_W'(col_nxt);
            out_item_nxt.data = '0;
          end
        end
      end

      ST_READ: begin
        out_valid_nxt     = 1'b1;
        out_item_nxt.row  = ROW_OUT_W'(row_r);
        out_item_nxt.col  = COL_OUT_W'(col_r);
        out_item_nxt.data = rdata_r;
        state_nxt         = ST_IDLE;
      end

      ST_SCROLL: begin
        // Read one row ahead, write the cell read in the previous cycle
        if (pend_r) begin
          we    = 1'b1;
          waddr = pend_addr_r;
          wdata = pend_blank_r ? BLANK_CELL : rdata_r;
        end
        if (cnt_r != CNT_W'(CELLS)) begin
          skip           = keep_r && (cnt_r >= CNT_W'(KEEP)) && (cnt_r < CNT_W'(COLS));
          pend_nxt       = !skip;
          pend_addr_nxt  = AW'(cnt_r);
          pend_blank_nxt = (cnt_r >= CNT_W'(SHIFT_CELLS));
          raddr          = pend_blank_nxt ? '0 : AW'(32'(cnt_r) + COLS);
          cnt_nxt        = cnt_r + CNT_W'(1);
        end else begin
          pend_nxt  = 1'b0;
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      keep_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        keep_r <= cfg_keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r  <= pend_addr_nxt;
    pend_blank_r <= pend_blank_nxt;
    out_item_r   <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

[hdl/text_console_char_engine_core.sv]
// Top level of the text console character engine.
// The engine keeps a ROWS x COLS screen of 16-bit cells and a cursor, takes one
// put or read item at a time and returns one result per item carrying the
// cursor position and, for a read, the stored cell. Items pass through a
// two-entry queue into a sequencer that owns a single-port-write,
// single-port-read screen memory. After reset the sequencer clears every cell
// of the memory, during which in_tready is low; configuration writes are taken
// as ever. A printable byte, a cursor move, an ignored byte or a read beyond
// the screen is handled in ST_IDLE alone; a read of a cell passes through
// ST_IDLE and then ST_READ. A scroll (newline or line wrap on the bottom row)
// runs in ST_SCROLL and a form feed in ST_FILL, both with at most one memory
// write per cycle; the result of such an item is delivered at its start.
module text_console_char_engine_core #(
  parameter int ROWS       = tcce_pkg::DEF_ROWS,
  parameter int COLS       = tcce_pkg::DEF_COLS,
  parameter int CLOCK_COLS = tcce_pkg::DEF_CLOCK_COLS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // keep_clock_area
  input  logic                             cfg_wr_en,
  input  logic [0:0]                       cfg_wr_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: char_code [7:0], cell_index [18:8], zero pad [23:19]
  input  logic [tcce_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: cmd [0]
  input  logic [0:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: cursor_row [4:0], cursor_col [11:5], cell_data [27:12], zero pad [31:28]
  output logic [tcce_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tcce_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - CELL_W - COL_OUT_W - ROW_OUT_W;

  q_entry_t  push_entry;
  q_entry_t  head_entry;
  logic      q_push, q_full, q_pop, q_valid;
  logic      init_busy;
  out_item_t out_item;

  tcce_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .init_busy(init_busy),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  tcce_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_entry(head_entry)
  );

  tcce_back #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .CLOCK_COLS(CLOCK_COLS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_keep (cfg_wr_data[0]),
    .q_valid  (q_valid),
    .q_entry  (head_entry),
    .q_pop    (q_pop),
    .init_busy(init_busy),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_item (out_item)
  );

  assign out_tdata = {PAD_W'(0), out_item};

endmodule

[hdl/tcce_checker.sv]
// Port-level assertions for the text console character engine, with bind.
module tcce_checker #(
  parameter int ROWS = tcce_pkg::DEF_ROWS,
  parameter int COLS = tcce_pkg::DEF_COLS
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tcce_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The screen clear after reset keeps the input closed
  a_init_closed: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input open during clear after reset");

  // No result appears straight out of reset
  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result right after reset");

  // The reported cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[11:5]) < COLS || COLS > 128) &&
                   (32'(out_tdata[4:0]) < ROWS || ROWS > 32))
    else $error("cursor off screen");

endmodule

bind text_console_char_engine_core tcce_checker #(
  .ROWS(ROWS),
  .COLS(COLS)
) u_tcce_checker (.*);
